>>> hw/rtl/cvh_pkg.sv
`timescale 1ns / 1ps
package cvh_pkg;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_EXT_RD,
      ST_EXT_CMP,
      ST_WALK_CHK,
      ST_OR_RD1,
      ST_OR_RD2,
      ST_OR_DIF,
      ST_OR_MUL,
      ST_OR_CMP,
      ST_FLT_LD,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_WAIT
   } state_type;

   typedef enum logic [1:0] {
      OUT_FAULT,
      OUT_LEFT,
      OUT_RIGHT
   } out_src_type;

   typedef struct packed {
      logic        wr_en;
      logic        wr_side;
      logic        cap_ab;
      logic        walk_right;
      logic        diff_en;
      logic        mul_en;
      logic        best_l_ld;
      logic        best_r_ld;
      logic        out_ld;
      out_src_type out_src;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic l_gt;
      logic r_lt;
      logic ori_neg;
      logic ori_pos;
   } dp_stat_type;

endpackage

>>> hw/rtl/cvh_if.sv
`timescale 1ns / 1ps
interface cvh_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   logic                         side;
   logic                         final_point;

   modport source (output valid, px, py, side, final_point, input ready);
   modport sink   (input valid, px, py, side, final_point, output ready);
endinterface

interface cvh_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic                         last_out;
   logic                         fault;

   modport source (output valid, out_x, out_y, last_out, fault, input ready);
   modport sink   (input valid, out_x, out_y, last_out, fault, output ready);
endinterface

>>> hw/rtl/cvh_dp.sv
`timescale 1ns / 1ps
module cvh_dp #(
   parameter int MAX_HULL   = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  cvh_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(MAX_HULL)-1:0]   wr_addr,
   input  logic [$clog2(MAX_HULL)-1:0]   rd_addr_l,
   input  logic [$clog2(MAX_HULL)-1:0]   rd_addr_r,
   input  logic signed [COORD_BITS-1:0]  in_x,
   input  logic signed [COORD_BITS-1:0]  in_y,
   output cvh_pkg::dp_stat_type          stat,
   output logic signed [COORD_BITS-1:0]  out_x,
   output logic signed [COORD_BITS-1:0]  out_y,
   output logic                          out_last,
   output logic                          out_fault
);
   import cvh_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int PW = 2 * CB;
   localparam int DW = CB + 1;
   localparam int MW = 2 * DW;

   logic [PW-1:0] mem_l [MAX_HULL];
   logic [PW-1:0] mem_r [MAX_HULL];
   logic [PW-1:0] rd_l_ff, rd_r_ff;

   logic signed [CB-1:0] rl_x, rl_y, rr_x, rr_y, c_x, c_y;
   logic signed [CB-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic signed [CB-1:0] best_l_ff, best_r_ff;
   logic signed [DW-1:0] d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [MW-1:0] p1_ff, p2_ff;
   logic signed [MW:0]   pd;
   logic signed [CB-1:0] out_x_ff, out_y_ff;
   logic                 out_last_ff, out_fault_ff;

   assign rl_x = rd_l_ff[PW-1:CB];
   assign rl_y = rd_l_ff[CB-1:0];
   assign rr_x = rd_r_ff[PW-1:CB];
   assign rr_y = rd_r_ff[CB-1:0];
   assign c_x  = cmd.walk_right ? rr_x : rl_x;
   assign c_y  = cmd.walk_right ? rr_y : rl_y;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && cmd.wr_side == SIDE_LEFT) begin
         mem_l[wr_addr] <= {in_x, in_y};
      end
      if (cmd.wr_en && cmd.wr_side == SIDE_RIGHT) begin
         mem_r[wr_addr] <= {in_x, in_y};
      end
      rd_l_ff <= mem_l[rd_addr_l];
      rd_r_ff <= mem_r[rd_addr_r];
   end

   // orientation: sign of (c.x-b.x)*(b.y-a.y) - (c.y-b.y)*(b.x-a.x)
   always_ff @(posedge clock) begin
      if (cmd.cap_ab) begin
         if (cmd.walk_right) begin
            a_x_ff <= rl_x;  a_y_ff <= rl_y;
            b_x_ff <= rr_x;  b_y_ff <= rr_y;
         end else begin
            a_x_ff <= rr_x;  a_y_ff <= rr_y;
            b_x_ff <= rl_x;  b_y_ff <= rl_y;
         end
      end
      if (cmd.diff_en) begin
         d1_ff <= DW'(c_x) - DW'(b_x_ff);
         d2_ff <= DW'(b_y_ff) - DW'(a_y_ff);
         d3_ff <= DW'(c_y) - DW'(b_y_ff);
         d4_ff <= DW'(b_x_ff) - DW'(a_x_ff);
      end
      if (cmd.mul_en) begin
         p1_ff <= d1_ff * d2_ff;
         p2_ff <= d3_ff * d4_ff;
      end
      if (cmd.best_l_ld) best_l_ff <= rl_x;
      if (cmd.best_r_ld) best_r_ff <= rr_x;
      if (cmd.out_ld) begin
         out_last_ff <= cmd.out_last;
         unique case (cmd.out_src)
            OUT_LEFT: begin
               out_x_ff     <= rl_x;
               out_y_ff     <= rl_y;
               out_fault_ff <= 1'b0;
            end
            OUT_RIGHT: begin
               out_x_ff     <= rr_x;
               out_y_ff     <= rr_y;
               out_fault_ff <= 1'b0;
            end
            default: begin
               out_x_ff     <= '0;
               out_y_ff     <= '0;
               out_fault_ff <= 1'b1;
            end
         endcase
      end
   end

   assign pd = (MW+1)'(p1_ff) - (MW+1)'(p2_ff);

   always_comb begin
      stat.l_gt    = rl_x > best_l_ff;
      stat.r_lt    = rr_x < best_r_ff;
      stat.ori_neg = pd[MW];
      stat.ori_pos = !pd[MW] && (pd != '0);
   end

   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_last  = out_last_ff;
   assign out_fault = out_fault_ff;

endmodule

>>> hw/rtl/cvh_ctrl.sv
`timescale 1ns / 1ps
module cvh_ctrl #(
   parameter int MAX_HULL = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_side,
   input  logic                         req_final,
   output logic                         req_ready,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output cvh_pkg::dp_cmd_type          cmd,
   input  cvh_pkg::dp_stat_type         stat,
   output logic [$clog2(MAX_HULL)-1:0]  wr_addr,
   output logic [$clog2(MAX_HULL)-1:0]  rd_addr_l,
   output logic [$clog2(MAX_HULL)-1:0]  rd_addr_r
);
   import cvh_pkg::*;

   localparam int IW = $clog2(MAX_HULL);
   localparam int CW = $clog2(MAX_HULL + 1);
   localparam int RW = CW + 1;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HULL);

   function automatic logic [IW-1:0] inc_mod(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] n);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt == n) ? '0 : nxt[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] dec_mod(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] n);
      logic [CW-1:0] prv;
      prv = n - CW'(1);
      return (idx == '0) ? prv[IW-1:0] : idx - IW'(1);
   endfunction

   state_type     state_ff, state_in;
   logic [CW-1:0] nl_ff, nl_in, nr_ff, nr_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in, s_ff, s_in;
   logic [RW-1:0] r_ff, r_in;
   logic [IW-1:0] il_ff, il_in, ir_ff, ir_in;
   logic [IW-1:0] wl_ff, wl_in, wr_ff, wr_in;
   logic [IW-1:0] ul_ff, ul_in, ur_ff, ur_in;
   logic [IW-1:0] ll_ff, ll_in, lr_ff, lr_in;
   logic [IW-1:0] ind_ff, ind_in;
   logic          done_ff, done_in, lower_ff, lower_in, second_ff, second_in;
   logic          em_right_ff, em_right_in, last_ff, last_in;

   logic          walk_right, brk, end_walk, em_last;
   logic [IW-1:0] cur, nx;
   logic [CW-1:0] n_side;
   logic [RW-1:0] rounds;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         nl_ff       <= '0;
         nr_ff       <= '0;
         ovf_ff      <= 1'b0;
         i_ff        <= '0;
         s_ff        <= '0;
         r_ff        <= '0;
         done_ff     <= 1'b0;
         lower_ff    <= 1'b0;
         second_ff   <= 1'b0;
         em_right_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         nl_ff       <= nl_in;
         nr_ff       <= nr_in;
         ovf_ff      <= ovf_in;
         i_ff        <= i_in;
         s_ff        <= s_in;
         r_ff        <= r_in;
         done_ff     <= done_in;
         lower_ff    <= lower_in;
         second_ff   <= second_in;
         em_right_ff <= em_right_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      il_ff  <= il_in;
      ir_ff  <= ir_in;
      wl_ff  <= wl_in;
      wr_ff  <= wr_in;
      ul_ff  <= ul_in;
      ur_ff  <= ur_in;
      ll_ff  <= ll_in;
      lr_ff  <= lr_in;
      ind_ff <= ind_in;
   end

   // first walk of a tangent steps forward and stops on a left turn,
   // the second steps backward and stops on a right turn
   assign walk_right = lower_ff ^ second_ff;
   assign cur        = walk_right ? wr_ff : wl_ff;
   assign n_side     = walk_right ? nr_ff : nl_ff;
   assign nx         = second_ff ? dec_mod(cur, n_side) : inc_mod(cur, n_side);
   assign rounds     = RW'(nl_ff) + RW'(nr_ff);
   assign brk        = second_ff ? stat.ori_pos : stat.ori_neg;
   assign em_last    = em_right_ff && ((ind_ff == ur_ff) || (s_ff + CW'(1) == nr_ff));

   always_comb begin
      state_in    = state_ff;
      nl_in       = nl_ff;
      nr_in       = nr_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      s_in        = s_ff;
      r_in        = r_ff;
      il_in       = il_ff;
      ir_in       = ir_ff;
      wl_in       = wl_ff;
      wr_in       = wr_ff;
      ul_in       = ul_ff;
      ur_in       = ur_ff;
      ll_in       = ll_ff;
      lr_in       = lr_ff;
      ind_in      = ind_ff;
      done_in     = done_ff;
      lower_in    = lower_ff;
      second_in   = second_ff;
      em_right_in = em_right_ff;
      last_in     = last_ff;
      cmd         = '0;
      wr_addr     = '0;
      rd_addr_l   = '0;
      rd_addr_r   = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      end_walk    = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_side == SIDE_RIGHT) begin
                  if (nr_ff < CNT_MAX) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_side = SIDE_RIGHT;
                     wr_addr     = nr_ff[IW-1:0];
                     nr_in       = nr_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  if (nl_ff < CNT_MAX) begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_side = SIDE_LEFT;
                     wr_addr     = nl_ff[IW-1:0];
                     nl_in       = nl_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_final) begin
                  if (nl_in == '0 || nr_in == '0 || ovf_in) begin
                     state_in = ST_FLT_LD;
                  end else begin
                     i_in     = '0;
                     state_in = ST_EXT_RD;
                  end
               end
            end
         end
         ST_EXT_RD: begin
            rd_addr_l = i_ff[IW-1:0];
            rd_addr_r = i_ff[IW-1:0];
            state_in  = ST_EXT_CMP;
         end
         ST_EXT_CMP: begin
            // strict compare keeps the first of equal extremes
            if (i_ff < nl_ff && (i_ff == '0 || stat.l_gt)) begin
               il_in         = i_ff[IW-1:0];
               cmd.best_l_ld = 1'b1;
            end
            if (i_ff < nr_ff && (i_ff == '0 || stat.r_lt)) begin
               ir_in         = i_ff[IW-1:0];
               cmd.best_r_ld = 1'b1;
            end
            i_in = i_ff + CW'(1);
            if (i_in >= nl_ff && i_in >= nr_ff) begin
               wl_in     = il_in;
               wr_in     = ir_in;
               lower_in  = 1'b0;
               second_in = 1'b0;
               done_in   = 1'b1;
               r_in      = '0;
               s_in      = '0;
               state_in  = ST_WALK_CHK;
            end else begin
               state_in = ST_EXT_RD;
            end
         end
         ST_WALK_CHK: begin
            if (s_ff >= n_side) begin
               end_walk = 1'b1;
            end else begin
               state_in = ST_OR_RD1;
            end
         end
         ST_OR_RD1: begin
            rd_addr_l = wl_ff;
            rd_addr_r = wr_ff;
            state_in  = ST_OR_RD2;
         end
         ST_OR_RD2: begin
            cmd.cap_ab     = 1'b1;
            cmd.walk_right = walk_right;
            if (walk_right) begin
               rd_addr_r = nx;
            end else begin
               rd_addr_l = nx;
            end
            state_in = ST_OR_DIF;
         end
         ST_OR_DIF: begin
            cmd.diff_en    = 1'b1;
            cmd.walk_right = walk_right;
            state_in       = ST_OR_MUL;
         end
         ST_OR_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_OR_CMP;
         end
         ST_OR_CMP: begin
            if (brk) begin
               end_walk = 1'b1;
            end else begin
               if (walk_right) begin
                  wr_in = nx;
               end else begin
                  wl_in = nx;
               end
               s_in = s_ff + CW'(1);
               if (second_ff) done_in = 1'b0;
               state_in = ST_WALK_CHK;
            end
         end
         ST_FLT_LD: begin
            cmd.out_ld   = 1'b1;
            cmd.out_src  = OUT_FAULT;
            cmd.out_last = 1'b1;
            last_in      = 1'b1;
            state_in     = ST_EM_WAIT;
         end
         ST_EM_RD: begin
            rd_addr_l = ind_ff;
            rd_addr_r = ind_ff;
            state_in  = ST_EM_LD;
         end
         ST_EM_LD: begin
            cmd.out_ld   = 1'b1;
            cmd.out_src  = em_right_ff ? OUT_RIGHT : OUT_LEFT;
            cmd.out_last = em_last;
            last_in      = em_last;
            state_in     = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_ff) begin
                  nl_in    = '0;
                  nr_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else if (!em_right_ff) begin
                  if (ind_ff == ll_ff || s_ff + CW'(1) == nl_ff) begin
                     em_right_in = 1'b1;
                     ind_in      = lr_ff;
                     s_in        = '0;
                  end else begin
                     ind_in = inc_mod(ind_ff, nl_ff);
                     s_in   = s_ff + CW'(1);
                  end
                  state_in = ST_EM_RD;
               end else begin
                  ind_in   = inc_mod(ind_ff, nr_ff);
                  s_in     = s_ff + CW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (end_walk) begin
         if (!second_ff) begin
            second_in = 1'b1;
            s_in      = '0;
            state_in  = ST_WALK_CHK;
         end else begin
            r_in = r_ff + RW'(1);
            if (done_ff || r_in >= rounds) begin
               if (!lower_ff) begin
                  ul_in     = wl_ff;
                  ur_in     = wr_ff;
                  wl_in     = il_ff;
                  wr_in     = ir_ff;
                  lower_in  = 1'b1;
                  second_in = 1'b0;
                  done_in   = 1'b1;
                  r_in      = '0;
                  s_in      = '0;
                  state_in  = ST_WALK_CHK;
               end else begin
                  ll_in       = wl_ff;
                  lr_in       = wr_ff;
                  em_right_in = 1'b0;
                  ind_in      = ul_ff;
                  s_in        = '0;
                  state_in    = ST_EM_RD;
               end
            end else begin
               second_in = 1'b0;
               done_in   = 1'b1;
               s_in      = '0;
               state_in  = ST_WALK_CHK;
            end
         end
      end
   end

endmodule

>>> hw/rtl/convex_hull_merge_top.sv
`timescale 1ns / 1ps
// Loading: one point beat per cycle; a point without final_point gives no result.
// Merge after the final point: a scan for the extreme points of both hulls, then
// orientation tests (memory read, diff, multiply, compare) for each tangent walk, with a
// step-cap check before each test; each result beat is then read, loaded and held until taken.
// One merge at a time: the next point is taken once the last result is taken.
// Synchronous active-high reset empties both hulls; point memories are not cleared.
module convex_hull_merge_top #(
   parameter int MAX_HULL   = 32,
   parameter int COORD_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   cvh_req_if.sink  req_if,
   cvh_rsp_if.source rsp_if
);
   import cvh_pkg::*;

   localparam int IW = $clog2(MAX_HULL);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [IW-1:0] wr_addr, rd_addr_l, rd_addr_r;

   cvh_ctrl #(
      .MAX_HULL (MAX_HULL)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_side  (req_if.side),
      .req_final (req_if.final_point),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd),
      .stat      (stat),
      .wr_addr   (wr_addr),
      .rd_addr_l (rd_addr_l),
      .rd_addr_r (rd_addr_r)
   );

   cvh_dp #(
      .MAX_HULL   (MAX_HULL),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr_l (rd_addr_l),
      .rd_addr_r (rd_addr_r),
      .in_x      (req_if.px),
      .in_y      (req_if.py),
      .stat      (stat),
      .out_x     (rsp_if.out_x),
      .out_y     (rsp_if.out_y),
      .out_last  (rsp_if.last_out),
      .out_fault (rsp_if.fault)
   );

endmodule

>>> test/tb_convex_hull_merge_top.sv
`timescale 1ns / 1ps
module tb_convex_hull_merge_top;
   import cvh_pkg::*;

   localparam int MAX_HULL   = 32;
   localparam int COORD_BITS = 16;
   localparam int N_ITEMS    = 410;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      fault;
   } hull_beat_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      side;
      logic      fin;
      logic      typed;
      coord_type ex;
      coord_type ey;
      logic      elast;
      logic      efault;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cvh_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   cvh_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   convex_hull_merge_top #(.MAX_HULL(MAX_HULL), .COORD_BITS(COORD_BITS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hull mirror
   coord_type hl_x [MAX_HULL];
   coord_type hl_y [MAX_HULL];
   coord_type hr_x [MAX_HULL];
   coord_type hr_y [MAX_HULL];
   int        n_left, n_right;
   bit        ovf_seen;
   hull_beat_type merged_q [$];

   int errors     = 0;
   int n_sent     = 0;
   int n_beats    = 0;
   int n_merges   = 0;
   int n_faults   = 0;
   bit hold_rsp   = 1'b0;
   bit no_idle    = 1'b0;
   dir_row_type rows [$];

   function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
      longint d;
      d = (cx - bx) * (by - ay) - (cy - by) * (bx - ax);
      return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic merge_hulls();
      int il, ir, ul, ur, ll, lr, nx, ind, rounds;
      bit done;
      hull_beat_type b;
      il = 0;
      ir = 0;
      for (int i = 1; i < n_left; i++) if (hl_x[i] > hl_x[il]) il = i;
      for (int i = 1; i < n_right; i++) if (hr_x[i] < hr_x[ir]) ir = i;
      rounds = n_left + n_right;
      ul = il; ur = ir; done = 1'b0;
      for (int r = 0; r < rounds && !done; r++) begin
         done = 1'b1;
         for (int s = 0; s < n_left; s++) begin
            nx = (ul + 1) % n_left;
            if (orient(hr_x[ur], hr_y[ur], hl_x[ul], hl_y[ul], hl_x[nx], hl_y[nx]) < 0) break;
            ul = nx;
         end
         for (int s = 0; s < n_right; s++) begin
            nx = (ur + n_right - 1) % n_right;
            if (orient(hl_x[ul], hl_y[ul], hr_x[ur], hr_y[ur], hr_x[nx], hr_y[nx]) > 0) break;
            ur = nx;
            done = 1'b0;
         end
      end
      ll = il; lr = ir; done = 1'b0;
      for (int r = 0; r < rounds && !done; r++) begin
         done = 1'b1;
         for (int s = 0; s < n_right; s++) begin
            nx = (lr + 1) % n_right;
            if (orient(hl_x[ll], hl_y[ll], hr_x[lr], hr_y[lr], hr_x[nx], hr_y[nx]) < 0) break;
            lr = nx;
         end
         for (int s = 0; s < n_left; s++) begin
            nx = (ll + n_left - 1) % n_left;
            if (orient(hr_x[lr], hr_y[lr], hl_x[ll], hl_y[ll], hl_x[nx], hl_y[nx]) > 0) break;
            ll = nx;
            done = 1'b0;
         end
      end
      ind = ul;
      for (int s = 0; s < n_left; s++) begin
         b = '{hl_x[ind], hl_y[ind], 1'b0, 1'b0};
         merged_q.push_back(b);
         if (ind == ll) break;
         ind = (ind + 1) % n_left;
      end
      ind = lr;
      for (int s = 0; s < n_right; s++) begin
         b = '{hr_x[ind], hr_y[ind], 1'b0, 1'b0};
         merged_q.push_back(b);
         if (ind == ur) break;
         ind = (ind + 1) % n_right;
      end
      merged_q[merged_q.size()-1].last = 1'b1;
   endtask

   // store one accepted point; on final, push the expected merged hull or fault beat when push is set
   task automatic load_point(coord_type x, coord_type y, logic side, logic fin, bit push);
      hull_beat_type b;
      if (side == SIDE_RIGHT) begin
         if (n_right < MAX_HULL) begin
            hr_x[n_right] = x; hr_y[n_right] = y; n_right++;
         end else ovf_seen = 1'b1;
      end else begin
         if (n_left < MAX_HULL) begin
            hl_x[n_left] = x; hl_y[n_left] = y; n_left++;
         end else ovf_seen = 1'b1;
      end
      if (fin) begin
         n_merges++;
         if (n_left == 0 || n_right == 0 || ovf_seen) begin
            n_faults++;
            b = '{'0, '0, 1'b1, 1'b1};
            if (push) merged_q.push_back(b);
         end else if (push) merge_hulls();
         n_left = 0;
         n_right = 0;
         ovf_seen = 1'b0;
      end
   endtask

   task automatic send_point(coord_type x, coord_type y, logic side, logic fin, bit push);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.px          <= x;
      req_bus.py          <= y;
      req_bus.side        <= side;
      req_bus.final_point <= fin;
      do @(posedge clock); while (!req_bus.ready);
      load_point(x, y, side, fin, push);
      n_sent++;
      @(negedge clock);
   endtask

   // convex polygon on a circle, counterclockwise
   task automatic send_hull(int cnt, logic side, bit fin_last);
      real ang [$];
      real cx, cy, rad;
      coord_type x, y;
      for (int i = 0; i < cnt; i++) ang.push_back($urandom_range(0, 62831) / 10000.0);
      ang.sort();
      rad = $urandom_range(1, 9000);
      cx  = (side == SIDE_RIGHT) ? $itor($urandom_range(10000, 20000))
                                 : -$itor($urandom_range(10000, 20000));
      cy  = $itor($urandom_range(0, 20000)) - 10000.0;
      for (int i = 0; i < cnt; i++) begin
         x = coord_type'($rtoi(cx + rad * $cos(ang[i])));
         y = coord_type'($rtoi(cy + rad * $sin(ang[i])));
         send_point(x, y, side, fin_last && (i == cnt - 1), 1'b1);
      end
   endtask

   task automatic add_row(int x, int y, logic side, logic fin, logic typed);
      dir_row_type r;
      r = '{coord_type'(x), coord_type'(y), side, fin, typed, '0, '0, 1'b1, 1'b1};
      rows.push_back(r);
   endtask

   // result checker
   always @(posedge clock) begin
      hull_beat_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_beats++;
         if (merged_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat x=%0d y=%0d last=%0b fault=%0b", $time,
                     rsp_bus.out_x, rsp_bus.out_y, rsp_bus.last_out, rsp_bus.fault);
         end else begin
            e = merged_q.pop_front();
            if (rsp_bus.out_x !== e.x || rsp_bus.out_y !== e.y ||
                rsp_bus.last_out !== e.last || rsp_bus.fault !== e.fault) begin
               errors++;
               $display("%0t: mismatch expected x=%0d y=%0d last=%0b fault=%0b", $time,
                        e.x, e.y, e.last, e.fault);
               $display("%0t:          actual   x=%0d y=%0d last=%0b fault=%0b", $time,
                        rsp_bus.out_x, rsp_bus.out_y, rsp_bus.last_out, rsp_bus.fault);
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      int g;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (g) @(negedge clock);
            end else rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #30ms;
      $display("timeout with %0d beats outstanding", merged_q.size());
      $display("simulation failed");
      $finish;
   end

   initial begin
      int n, nl, nr, mode;
      req_bus.valid       = 1'b0;
      req_bus.px          = '0;
      req_bus.py          = '0;
      req_bus.side        = 1'b0;
      req_bus.final_point = 1'b0;
      n_left = 0; n_right = 0; ovf_seen = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty right side, empty left side, extremes, small shapes
      add_row(5, 5, SIDE_LEFT, 1'b1, 1'b1);
      add_row(7, -3, SIDE_RIGHT, 1'b1, 1'b1);
      add_row(-32768, -32768, SIDE_LEFT, 1'b0, 1'b0);
      add_row(-32768, 32767, SIDE_LEFT, 1'b0, 1'b0);
      add_row(32767, 32767, SIDE_RIGHT, 1'b0, 1'b0);
      add_row(32767, -32768, SIDE_RIGHT, 1'b1, 1'b0);
      // single point on each side
      add_row(-1, 0, SIDE_LEFT, 1'b0, 1'b0);
      add_row(1, 0, SIDE_RIGHT, 1'b1, 1'b0);
      // collinear hulls
      add_row(-30, 0, SIDE_LEFT, 1'b0, 1'b0);
      add_row(-20, 0, SIDE_LEFT, 1'b0, 1'b0);
      add_row(-10, 0, SIDE_LEFT, 1'b0, 1'b0);
      add_row(10, 0, SIDE_RIGHT, 1'b0, 1'b0);
      add_row(20, 0, SIDE_RIGHT, 1'b1, 1'b0);
      // two triangles
      add_row(-40, -10, SIDE_LEFT, 1'b0, 1'b0);
      add_row(-10, 0, SIDE_LEFT, 1'b0, 1'b0);
      add_row(-40, 10, SIDE_LEFT, 1'b0, 1'b0);
      add_row(30, -20, SIDE_RIGHT, 1'b0, 1'b0);
      add_row(60, 0, SIDE_RIGHT, 1'b0, 1'b0);
      add_row(30, 20, SIDE_RIGHT, 1'b1, 1'b0);
      // right only, then final on right
      add_row(100, 100, SIDE_RIGHT, 1'b1, 1'b1);
      foreach (rows[i]) begin
         send_point(rows[i].x, rows[i].y, rows[i].side, rows[i].fin, !rows[i].typed);
         if (rows[i].typed)
            merged_q.push_back('{rows[i].ex, rows[i].ey, rows[i].elast, rows[i].efault});
      end

      // overflow: one point too many on the left
      for (int i = 0; i <= MAX_HULL; i++)
         send_point(coord_type'($urandom), coord_type'($urandom), SIDE_LEFT, 1'b0, 1'b1);
      send_point(coord_type'($urandom), coord_type'($urandom), SIDE_RIGHT, 1'b1, 1'b1);

      // long hold on results while points keep coming
      hold_rsp = 1'b1;
      send_hull(6, SIDE_LEFT, 1'b0);
      send_hull(6, SIDE_RIGHT, 1'b1);
      send_hull(4, SIDE_LEFT, 1'b0);
      send_hull(4, SIDE_RIGHT, 1'b1);
      wait (merged_q.size() == 0);
      @(negedge clock);

      n = 0;
      while (n_sent < N_ITEMS) begin
         n++;
         no_idle = (n % 9 == 4);
         mode = $urandom_range(0, 99);
         nl = ($urandom_range(0, 19) == 0) ? MAX_HULL : $urandom_range(1, 8);
         nr = ($urandom_range(0, 19) == 0) ? MAX_HULL : $urandom_range(1, 8);
         if (mode < 70) begin
            send_hull(nl, SIDE_LEFT, 1'b0);
            send_hull(nr, SIDE_RIGHT, 1'b1);
         end else if (mode < 80) begin
            // noise: random points, random side
            repeat (nl) send_point(coord_type'($urandom), coord_type'($urandom),
                                   1'($urandom_range(0, 1)), 1'b0, 1'b1);
            send_point(coord_type'($urandom), coord_type'($urandom),
                       1'($urandom_range(0, 1)), 1'b1, 1'b1);
         end else if (mode < 86) begin
            // empty right side
            send_hull(nl, SIDE_LEFT, 1'b1);
         end else if (mode < 90) begin
            repeat (MAX_HULL + 1) send_point(coord_type'($urandom), coord_type'($urandom),
                                             SIDE_RIGHT, 1'b0, 1'b1);
            send_hull(nl, SIDE_LEFT, 1'b1);
         end else begin
            // right hull first, final on the left
            send_hull(nr, SIDE_RIGHT, 1'b0);
            send_hull(nl, SIDE_LEFT, 1'b1);
         end
         if (n % 11 == 0) begin
            wait (merged_q.size() == 0);
            @(negedge clock);
         end
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      wait (merged_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("%0d points sent, %0d merges (%0d refused), %0d result beats checked",
               n_sent, n_merges, n_faults, n_beats);
      $display("errors: %0d", errors);
      if (errors == 0 && merged_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
